// ----- hdl/bffl_pkg.sv -----
package bffl_pkg;

  typedef struct packed {
    logic        command;
    logic [11:0] request_size;
    logic [19:0] block_address;
  } bffl_req_t;

  typedef struct packed {
    logic [19:0] payload_address;
    logic [2:0]  status;
  } bffl_rsp_t;

  localparam logic CMD_ALLOC = 1'b0;
  localparam logic CMD_FREE  = 1'b1;

  localparam logic [2:0] ST_ALLOCATED = 3'd0;
  localparam logic [2:0] ST_FREED     = 3'd1;
  localparam logic [2:0] ST_BAD_SIZE  = 3'd2;
  localparam logic [2:0] ST_NO_PAGES  = 3'd3;
  localparam logic [2:0] ST_FULL      = 3'd4;
  localparam logic [2:0] ST_UNKNOWN   = 3'd5;

  typedef enum logic [3:0] {
    S_IDLE,
    S_FSCAN,
    S_FEVAL,
    S_UPICK,
    S_UREAD,
    S_UCMP,
    S_DECIDE,
    S_TAKE,
    S_TAKE2,
    S_FREE_PUT,
    S_DONE
  } bffl_state_t;

endpackage

// ----- hdl/best_fit_free_list_allocator_unit.sv -----
// channel | ports                         | handshake
// request | in_req                        | taken when start && !busy
// result  | out_rsp                       | out_valid for one cycle, no backpressure
// An allocate scans every free slot (one memory read a cycle), then decides (S_DECIDE),
// writes the chosen slot and the used entry (S_TAKE, S_TAKE2) and strobes in S_DONE.
// A zero, oversized or table-full allocate strobes in the cycle after acceptance.
// A free reads and compares the used entries in turn (S_UREAD, then S_UCMP) until
// one hits or the last has been compared; on a hit it passes S_FREE_PUT before the
// strobe in S_DONE, on a miss it goes straight to S_DONE.
// rst_n is synchronous; it clears valid bits, counters and the sequencer.
// busy stays high from acceptance until the result strobe.
module best_fit_free_list_allocator_unit import bffl_pkg::*; #(
  parameter int PAGE_BYTES   = 4096,
  parameter int HEADER_BYTES = 16,
  parameter int FREE_SLOTS   = 64,
  parameter int USED_SLOTS   = 64,
  parameter int PAGE_COUNT   = 256
) (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      start,
  output logic      busy,
  input  bffl_req_t in_req,
  output logic      out_valid,
  output bffl_rsp_t out_rsp
);
  localparam int FW = $clog2(FREE_SLOTS);
  localparam int UW = $clog2(USED_SLOTS);
  localparam int PW = $clog2(PAGE_COUNT + 1);
  localparam int PAYLOAD = PAGE_BYTES - HEADER_BYTES;
  localparam int MAXREQ = (PAYLOAD < 4095) ? PAYLOAD : 4095;
  localparam logic [FW:0] FLAST = (FW+1)'(FREE_SLOTS - 1);
  localparam logic [UW:0] ULAST = (UW+1)'(USED_SLOTS - 1);

  logic [19:0] slot_off_mem [FREE_SLOTS];
  logic [11:0] slot_bytes_mem [FREE_SLOTS];
  logic [31:0] slot_stamp_mem [FREE_SLOTS];
  logic [FREE_SLOTS-1:0] slot_valid_r;
  logic [19:0] used_addr_mem [USED_SLOTS];
  logic [11:0] used_bytes_mem [USED_SLOTS];
  logic [USED_SLOTS-1:0] used_valid_r;

  bffl_state_t state_r, state_nxt;
  bffl_req_t   req_r;
  logic [31:0] ctr_r;
  logic [PW-1:0] pages_r;
  logic [FW:0] fi_r;
  logic [UW:0] ui_r;
  logic [FW-1:0] fidx_d_r;
  logic [19:0] rd_off_r;
  logic [11:0] rd_bytes_r;
  logic [31:0] rd_stamp_r;
  logic [19:0] rd_uaddr_r;
  logic [11:0] rd_ubytes_r;
  logic        rd_ok_r;
  logic        best_ok_r;
  logic [FW-1:0] best_r;
  logic [11:0] best_diff_r;
  logic [31:0] best_stamp_r;
  logic [19:0] best_off_r;
  logic [11:0] best_bytes_r;
  logic        fempty_ok_r, uempty_ok_r;
  logic [FW-1:0] fempty_r;
  logic [UW-1:0] uempty_r;
  logic [UW-1:0] uhit_r;
  logic [2:0]  st_r;
  logic [19:0] paddr_r;

  // lowest empty entries, priority search over valid bits
  always_comb begin
    fempty_r = '0; fempty_ok_r = 1'b0;
    for (int i = FREE_SLOTS - 1; i >= 0; i--)
      if (!slot_valid_r[i]) begin fempty_r = FW'(i); fempty_ok_r = 1'b1; end
    uempty_r = '0; uempty_ok_r = 1'b0;
    for (int i = USED_SLOTS - 1; i >= 0; i--)
      if (!used_valid_r[i]) begin uempty_r = UW'(i); uempty_ok_r = 1'b1; end
  end

  logic [11:0] diff;
  logic        fits;
  logic [11:0] surplus;
  logic [19:0] payload;
  assign diff = rd_bytes_r - req_r.request_size;
  assign fits = rd_ok_r && (rd_bytes_r >= req_r.request_size);
  assign surplus = best_bytes_r - req_r.request_size;
  assign payload = best_off_r + 20'(HEADER_BYTES);

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      S_IDLE: if (start) begin
        if (in_req.command == CMD_FREE) state_nxt = S_UREAD;
        else if (in_req.request_size == 12'd0 || 32'(in_req.request_size) > MAXREQ
                 || !uempty_ok_r) state_nxt = S_DONE;
        else state_nxt = S_FSCAN;
      end
      S_FSCAN:  state_nxt = S_FEVAL;
      S_FEVAL:  state_nxt = (fi_r == '0) ? S_DECIDE : S_FEVAL;
      S_UREAD:  state_nxt = S_UCMP;
      S_UCMP: begin
        if (rd_ok_r && rd_uaddr_r == req_r.block_address) state_nxt = S_FREE_PUT;
        else if (ui_r > ULAST) state_nxt = S_DONE;
        else state_nxt = S_UREAD;
      end
      S_DECIDE: state_nxt = S_TAKE;
      S_TAKE:   state_nxt = S_TAKE2;
      S_TAKE2:  state_nxt = S_DONE;
      S_FREE_PUT: state_nxt = S_DONE;
      S_DONE:   state_nxt = S_IDLE;
      default:  state_nxt = S_IDLE;
    endcase
  end

  always_comb begin
    busy = (state_r != S_IDLE);
    out_valid = (state_r == S_DONE);
    out_rsp.payload_address = paddr_r;
    out_rsp.status = st_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) state_r <= S_IDLE;
    else state_r <= state_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      slot_valid_r <= '0;
      used_valid_r <= '0;
      ctr_r <= '0;
      pages_r <= '0;
    end else begin
      case (state_r)
        S_IDLE: if (start) begin
          req_r <= in_req;
          paddr_r <= '0;
          fi_r <= '0;
          ui_r <= '0;
          best_ok_r <= 1'b0;
          if (in_req.command == CMD_ALLOC) begin
            if (in_req.request_size == 12'd0 || 32'(in_req.request_size) > MAXREQ)
              st_r <= ST_BAD_SIZE;
            else st_r <= ST_FULL;
          end else st_r <= ST_UNKNOWN;
        end
        S_FSCAN, S_FEVAL: begin
          // read pipeline: issue fi_r, evaluate previous
          if (state_r == S_FEVAL && fits && (!best_ok_r || diff < best_diff_r ||
              (diff == best_diff_r && rd_stamp_r > best_stamp_r))) begin
            best_ok_r <= 1'b1; best_r <= fidx_d_r; best_diff_r <= diff;
            best_stamp_r <= rd_stamp_r; best_off_r <= rd_off_r;
            best_bytes_r <= rd_bytes_r;
          end
          if (fi_r <= FLAST) begin
            rd_off_r <= slot_off_mem[fi_r[FW-1:0]];
            rd_bytes_r <= slot_bytes_mem[fi_r[FW-1:0]];
            rd_stamp_r <= slot_stamp_mem[fi_r[FW-1:0]];
            rd_ok_r <= slot_valid_r[fi_r[FW-1:0]];
            fidx_d_r <= fi_r[FW-1:0];
            fi_r <= (fi_r == FLAST) ? '0 : fi_r + 1'b1;
          end
        end
        S_UREAD: begin
          rd_uaddr_r <= used_addr_mem[ui_r[UW-1:0]];
          rd_ubytes_r <= used_bytes_mem[ui_r[UW-1:0]];
          rd_ok_r <= used_valid_r[ui_r[UW-1:0]];
          uhit_r <= ui_r[UW-1:0];
          ui_r <= ui_r + 1'b1;
        end
        S_DECIDE: begin
          if (!best_ok_r) begin
            if (32'(pages_r) >= PAGE_COUNT) st_r <= ST_NO_PAGES;
            else if (fempty_ok_r) begin
              // fetch new page into lowest empty entry
              best_ok_r <= 1'b1; best_r <= fempty_r;
              best_off_r <= 20'(32'(pages_r) * PAGE_BYTES);
              best_bytes_r <= 12'(PAYLOAD);
              slot_stamp_mem[fempty_r] <= ctr_r;
              ctr_r <= ctr_r + 1'b1;
              pages_r <= pages_r + 1'b1;
            end
          end
        end
        S_TAKE: if (best_ok_r) begin
          // keep the entry only for a split remainder
          slot_valid_r[best_r] <= (surplus > 12'(HEADER_BYTES));
          if (surplus > 12'(HEADER_BYTES)) begin
            slot_off_mem[best_r] <= payload + 20'(req_r.request_size);
            slot_bytes_mem[best_r] <= surplus - 12'(HEADER_BYTES);
            slot_stamp_mem[best_r] <= ctr_r;
            ctr_r <= ctr_r + 1'b1;
          end
          used_addr_mem[uempty_r] <= payload;
          used_bytes_mem[uempty_r] <= req_r.request_size;
          paddr_r <= payload;
          st_r <= ST_ALLOCATED;
        end
        S_TAKE2: if (st_r == ST_ALLOCATED) used_valid_r[uempty_r] <= 1'b1;
        S_FREE_PUT: begin
          if (fempty_ok_r) begin
            slot_valid_r[fempty_r] <= 1'b1;
            slot_off_mem[fempty_r] <= req_r.block_address - 20'(HEADER_BYTES);
            slot_bytes_mem[fempty_r] <= rd_ubytes_r;
            slot_stamp_mem[fempty_r] <= ctr_r;
            ctr_r <= ctr_r + 1'b1;
            used_valid_r[uhit_r] <= 1'b0;
            st_r <= ST_FREED;
          end else st_r <= ST_FULL;
        end
        default: ;
      endcase
    end
  end
endmodule

// ----- hdl/bffl_checker.sv -----
module bffl_checker import bffl_pkg::*; (
  input logic      clk,
  input logic      rst_n,
  input logic      start,
  input logic      busy,
  input logic      out_valid,
  input bffl_rsp_t out_rsp
);
  a_busy_after_start: assert property (@(posedge clk) disable iff (!rst_n)
    start && !busy |=> busy) else $error("busy not raised");
  a_single_strobe: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |=> !out_valid) else $error("strobe longer than one cycle");
  a_release: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |=> !busy) else $error("busy stuck after result");
  a_addr_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_rsp.status != ST_ALLOCATED |-> out_rsp.payload_address == 20'd0)
    else $error("address on failed request");
endmodule

bind best_fit_free_list_allocator_unit bffl_checker u_bffl_checker (
  .clk(clk), .rst_n(rst_n), .start(start), .busy(busy),
  .out_valid(out_valid), .out_rsp(out_rsp));
